// ===== src/bsxlc_pkg.sv =====
// Package: shared constants, key table and bit shuffle functions for the letter codec.
package bsxlc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KEY_IDX_W = 4;
    localparam int unsigned KEY_LEN  = 16;

    localparam logic MODE_SCRAMBLE   = 1'b0;
    localparam logic MODE_DESCRAMBLE = 1'b1;

    localparam logic [BYTE_W-1:0] LETTER_BASE = 8'd65;   // 'A'

    typedef logic [BYTE_W-1:0] byte_t;

    function automatic byte_t key_at(input logic [KEY_IDX_W-1:0] idx);
        byte_t k;
        case (idx)
            4'd0:    k = 8'd89;
            4'd1:    k = 8'd52;
            4'd2:    k = 8'd178;
            4'd3:    k = 8'd9;
            4'd4:    k = 8'd56;
            4'd5:    k = 8'd86;
            4'd6:    k = 8'd114;
            4'd7:    k = 8'd5;
            4'd8:    k = 8'd29;
            4'd9:    k = 8'd98;
            4'd10:   k = 8'd156;
            4'd11:   k = 8'd209;
            4'd12:   k = 8'd243;
            4'd13:   k = 8'd73;
            4'd14:   k = 8'd198;
            4'd15:   k = 8'd101;
            default: k = 8'd0;
        endcase
        return k;
    endfunction

    // out bit <- in bit: 7<-2 6<-7 5<-3 4<-0 3<-1 2<-4 1<-6 0<-5
    function automatic byte_t shuffle_fwd(input byte_t v);
        return {v[2], v[7], v[3], v[0], v[1], v[4], v[6], v[5]};
    endfunction

    function automatic byte_t shuffle_inv(input byte_t v);
        return {v[6], v[1], v[0], v[2], v[5], v[7], v[3], v[4]};
    endfunction

endpackage

// ===== src/bit_shuffle_xor_letter_codec_core.sv =====
// Top level: bit shuffle / XOR key / two-letter byte codec with stream ports.
//
// Byte codec, mode picked per request on s_tuser[0]. Scramble (mode 0) permutes
// the byte's bits, XORs it with the next entry of a fixed 16-byte cyclic key and
// sends two letters ('A' + high nibble, then 'A' + low nibble, m_tlast on the
// second). Descramble (mode 1) takes letters in pairs: the first is held with no
// result, the second forms a byte that is XORed with the key, inverse-permuted
// and sent with m_tlast set. s_tuser[1] (first of message) restarts the key
// index and drops any held letter; a scramble request also drops a held letter.
// Timing: a request waits in the input register until the buffer has room; its
// first result is then written to slot0, which drives m_tdata. The two-entry
// result buffer drains one result per cycle while m_tready is high, so scramble
// sends one letter and descramble takes one letter per cycle, through one port.
module bit_shuffle_xor_letter_codec_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] in_byte
    input  logic [1:0]             s_tuser,   // [0] mode, [1] first_of_message
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] out_byte
    output logic                   m_tlast    // last result of this request
);
    import bsxlc_pkg::*;

    // Input register
    logic                 in_vld_reg, in_vld_next;
    logic                 in_mode_reg;
    logic                 in_first_reg;
    byte_t                in_byte_reg;

    // Codec state
    logic [KEY_IDX_W-1:0] key_idx_reg, key_idx_next;
    logic                 phase_reg, phase_next;
    byte_t                held_reg, held_next;

    // Result buffer: slot0 is on the port, slot1 waits behind it
    logic [1:0]           cnt_reg, cnt_next;
    byte_t                slot0_reg, slot0_next;
    byte_t                slot1_reg, slot1_next;

    logic                 pop;
    logic                 adv;
    logic                 s_acc;
    logic [KEY_IDX_W-1:0] key_idx_eff;
    logic                 phase_eff;
    byte_t                key_val;
    byte_t                enc_val;
    byte_t                pair_val;
    byte_t                dec_val;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg;
    assign m_tlast  = (cnt_reg == 2'd1);
    assign pop      = m_tvalid && m_tready;

    // The stage may hand over when the buffer is empty or empties this cycle.
    assign adv      = in_vld_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready));
    assign s_tready = !in_vld_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    // Start of message resets key position and pairing before the request.
    assign key_idx_eff = in_first_reg ? '0 : key_idx_reg;
    assign phase_eff   = in_first_reg ? 1'b0 : phase_reg;
    assign key_val     = key_at(key_idx_eff);
    assign enc_val     = shuffle_fwd(in_byte_reg) ^ key_val;
    // (hi - 'A') * 16 + (lo - 'A'), modulo 256
    assign pair_val    = {4'(held_reg - LETTER_BASE), 4'd0} + (in_byte_reg - LETTER_BASE);
    assign dec_val     = shuffle_inv(pair_val ^ key_val);

    always_comb begin
        in_vld_next  = in_vld_reg;
        key_idx_next = key_idx_reg;
        phase_next   = phase_reg;
        held_next    = held_reg;
        cnt_next     = cnt_reg;
        slot0_next   = slot0_reg;
        slot1_next   = slot1_reg;

        if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end

        if (adv) begin
            key_idx_next = key_idx_eff;
            phase_next   = phase_eff;
            if (in_mode_reg == MODE_SCRAMBLE) begin
                key_idx_next = key_idx_eff + 1'b1;
                phase_next   = 1'b0;
                cnt_next     = 2'd2;
                slot0_next   = LETTER_BASE + {4'd0, enc_val[7:4]};
                slot1_next   = LETTER_BASE + {4'd0, enc_val[3:0]};
            end else if (!phase_eff) begin
                // first letter of a pair: hold it, no result
                held_next  = in_byte_reg;
                phase_next = 1'b1;
            end else begin
                key_idx_next = key_idx_eff + 1'b1;
                phase_next   = 1'b0;
                cnt_next     = 2'd1;
                slot0_next   = dec_val;
            end
        end

        if (s_acc) begin
            in_vld_next = 1'b1;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            key_idx_reg <= '0;
            phase_reg   <= 1'b0;
            held_reg    <= '0;
            cnt_reg     <= 2'd0;
        end else begin
            in_vld_reg  <= in_vld_next;
            key_idx_reg <= key_idx_next;
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        if (s_acc) begin
            in_mode_reg  <= s_tuser[0];
            in_first_reg <= s_tuser[1];
            in_byte_reg  <= s_tdata;
        end
    end

    // Buffer never holds more than two results.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer overfilled");

    // A scrambled byte always queues exactly two letters.
    a_scr_two: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (in_mode_reg == MODE_SCRAMBLE) |=> cnt_reg == 2'd2)
        else $error("scramble did not queue two letters");

    // Key position steps by one per scrambled byte within a message.
    a_key_step: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (in_mode_reg == MODE_SCRAMBLE) && !in_first_reg
        |=> key_idx_reg == $past(key_idx_reg) + 4'd1)
        else $error("key index did not advance");

    // Scramble drops any held letter.
    a_scr_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (in_mode_reg == MODE_SCRAMBLE) |=> !phase_reg)
        else $error("pairing not cleared by scramble");

endmodule

// ===== bench/bsxlc_checker.sv =====
// Checker for the letter codec: predicts every result from the accepted requests and compares.
module bsxlc_checker
    import bsxlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output logic [31:0] fail_count,
    output logic [31:0] outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        byte_t data;
        logic  last;
    } codec_out_t;

    // cyclic key, entry 0 in the low byte
    localparam logic [KEY_LEN*8-1:0] KEY_ROM = {
        8'd101, 8'd198, 8'd73,  8'd243, 8'd209, 8'd156, 8'd98, 8'd29,
        8'd5,   8'd114, 8'd86,  8'd56,  8'd9,   8'd178, 8'd52, 8'd89
    };
    // source bit of each mixed bit, out bit 0 in the low field
    localparam logic [23:0] MIX_SRC = {3'd2, 3'd7, 3'd3, 3'd0, 3'd1, 3'd4, 3'd6, 3'd5};

    logic [KEY_IDX_W-1:0] key_pos;
    logic                 letter_held;
    byte_t                held_letter;
    codec_out_t           codec_out_q[$];
    logic [31:0]          errors = '0;

    assign fail_count = errors;

    function automatic byte_t bit_mix(input byte_t v);
        byte_t r;
        for (int i = 0; i < 8; i++) r[i] = v[MIX_SRC[3*i +: 3]];
        return r;
    endfunction

    function automatic byte_t bit_unmix(input byte_t v);
        byte_t r;
        for (int i = 0; i < 8; i++) r[MIX_SRC[3*i +: 3]] = v[i];
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    task automatic codec_step(input logic mode, input byte_t b, input logic first);
        byte_t      v;
        codec_out_t r;
        if (first) begin
            key_pos     = '0;
            letter_held = 1'b0;
        end
        if (mode == MODE_SCRAMBLE) begin
            v = bit_mix(b) ^ KEY_ROM[8*key_pos +: 8];
            key_pos = key_pos + 1'b1;
            letter_held = 1'b0;
            r.data = {4'h0, v[7:4]} + LETTER_BASE;
            r.last = 1'b0;
            codec_out_q.push_back(r);
            r.data = {4'h0, v[3:0]} + LETTER_BASE;
            r.last = 1'b1;
            codec_out_q.push_back(r);
        end else if (!letter_held) begin
            held_letter = b;
            letter_held = 1'b1;
        end else begin
            // wraps modulo 256 for letters outside A..P
            v = ((held_letter - LETTER_BASE) << 4) + (b - LETTER_BASE);
            v = v ^ KEY_ROM[8*key_pos +: 8];
            key_pos = key_pos + 1'b1;
            letter_held = 1'b0;
            r.data = bit_unmix(v);
            r.last = 1'b1;
            codec_out_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        codec_out_t want;
        if (!aresetn) begin
            key_pos     = '0;
            letter_held = 1'b0;
            held_letter = '0;
            codec_out_q.delete();
        end else begin
            if (s_tvalid && s_tready) codec_step(s_tuser[0], s_tdata, s_tuser[1]);
            if (m_tvalid && m_tready) begin
                if (codec_out_q.size() == 0) begin
                    report($sformatf("result %02h with nothing pending", m_tdata));
                end else begin
                    want = codec_out_q.pop_front();
                    if (m_tdata !== want.data)
                        report($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
                    if (m_tlast !== want.last)
                        report($sformatf("last %b, want %b", m_tlast, want.last));
                end
            end
        end
        outstanding <= codec_out_q.size();
    end

endmodule

// ===== bench/tb_bit_shuffle_xor_letter_codec_core.sv =====
// Testbench top for the letter codec: clock, reset, request and result traffic, verdict.
module tb_bit_shuffle_xor_letter_codec_core;
    import bsxlc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_COUNT  = 1600;
    localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int unsigned BURST_ITEMS = 40;    // gapless requests during the hold-off
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 16;    // extra settle time after the drain

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] in_byte
    logic [1:0]  s_tuser  = '0;   // [0] mode, [1] first_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] out_byte
    logic        m_tlast;
    logic [31:0] fail_count;
    logic [31:0] outstanding;

    // idling switches, redrawn per message so some stretches run without gaps
    bit          tx_idle  = 1'b1;
    bit          rx_idle  = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned sent     = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    bit_shuffle_xor_letter_codec_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bsxlc_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Offer one request after an optional gap; returns at the edge that takes it.
    // s_tvalid stays high into the next call, so back-to-back requests need no drop.
    task automatic send_request(input logic mode, input byte_t b, input logic first);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(19, 0) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {first, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    // Mostly an A..P letter so pairs decode cleanly; now and then any byte.
    function automatic byte_t pick_letter();
        if ($urandom_range(7, 0) == 0) return byte_t'($urandom_range(255, 0));
        return LETTER_BASE + byte_t'($urandom_range(15, 0));
    endfunction

    // One message: first_of_message on its opening request.
    task automatic send_message();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(99, 0);
        len  = $urandom_range(24, 1);
        if (kind < 55) begin
            // plain bytes to scramble
            for (int i = 0; i < len; i++)
                send_request(MODE_SCRAMBLE, byte_t'($urandom_range(255, 0)), i == 0);
        end else if (kind < 85) begin
            // letter pairs, sometimes with a dangling odd letter at the end
            for (int i = 0; i < 2*len; i++)
                send_request(MODE_DESCRAMBLE, pick_letter(), i == 0);
            if ($urandom_range(5, 0) == 0)
                send_request(MODE_DESCRAMBLE, pick_letter(), 1'b0);
        end else begin
            // noise: mixed modes, stray restarts, broken pairs
            for (int i = 0; i < len; i++)
                send_request(logic'($urandom_range(1, 0)), byte_t'($urandom_range(255, 0)),
                             i == 0 || $urandom_range(7, 0) == 0);
        end
    endtask

    // Result side: per result a random stall, plus one long hold-off on request.
    initial begin
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = rx_idle ? $urandom_range(19, 0) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        bit          burst_done;
        bit          pause_done;
        int unsigned w;
        burst_done = 1'b0;
        pause_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // scramble at the byte extremes and alternating bit patterns
        send_request(MODE_SCRAMBLE, 8'h00, 1'b1);
        send_request(MODE_SCRAMBLE, 8'hFF, 1'b0);
        send_request(MODE_SCRAMBLE, 8'h55, 1'b0);
        send_request(MODE_SCRAMBLE, 8'hAA, 1'b0);
        send_request(MODE_SCRAMBLE, 8'h81, 1'b0);
        // letter pairs at both ends of A..P
        send_request(MODE_DESCRAMBLE, LETTER_BASE, 1'b1);
        send_request(MODE_DESCRAMBLE, LETTER_BASE, 1'b0);
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd15, 1'b0);
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd15, 1'b0);
        // non-letters: the pair arithmetic wraps
        send_request(MODE_DESCRAMBLE, 8'h00, 1'b0);
        send_request(MODE_DESCRAMBLE, 8'hFF, 1'b0);
        send_request(MODE_DESCRAMBLE, 8'hFF, 1'b0);
        send_request(MODE_DESCRAMBLE, 8'h00, 1'b0);
        // dangling letter dropped by a new message
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd2, 1'b0);
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd3, 1'b1);
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd4, 1'b0);
        // dangling letter dropped by a scramble, then modes mixed within one message
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd5, 1'b0);
        send_request(MODE_SCRAMBLE, 8'h3C, 1'b0);
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd6, 1'b0);
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd7, 1'b0);
        // restart on what would have been the second letter of a pair
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd8, 1'b0);
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd9, 1'b1);
        send_request(MODE_DESCRAMBLE, LETTER_BASE + 8'd10, 1'b0);

        // --- random part ---
        while (sent < ITEM_COUNT) begin
            tx_idle = $urandom_range(3, 0) != 0;
            rx_idle = $urandom_range(3, 0) != 0;
            if (!burst_done && sent >= ITEM_COUNT / 3) begin
                // receiver holds off while requests keep coming: block fills and stalls
                burst_done = 1'b1;
                tx_idle = 1'b0;
                hold_req = 1'b1;
                for (int i = 0; i < BURST_ITEMS; i++)
                    send_request(MODE_SCRAMBLE, byte_t'($urandom_range(255, 0)), i == 0);
            end else if (!pause_done && sent >= (2 * ITEM_COUNT) / 3) begin
                // sender pauses until every pending result is out
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (outstanding != 0) @(posedge aclk);
            end
            send_message();
        end
        s_tvalid <= 1'b0;

        // let the counter settle past the last accepted request, then drain
        @(posedge aclk);
        for (w = 0; w < DRAIN_LIMIT && outstanding != 0; w++) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit: several times the slowest correct run
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
